// File: rtl/gsuf_pkg.sv
// ----------------------------------------------------------------------------
// gsuf_pkg
// Shared types and constants of the segmentation union-find engine.
// ----------------------------------------------------------------------------
package gsuf_pkg;

    // Field widths fixed by the interface
    localparam int VTX_W      = 16;
    localparam int THR_W      = 24;
    localparam int LIMIT_W    = 17;
    localparam int OSIZE_W    = 17;
    localparam int OCOUNT_W   = 17;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 1;

    // Default vertex count
    localparam int VERTICES_DEF = 65536;

    // Register reset values
    localparam logic [THR_W-1:0]   K_RESET     = 24'd128000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd0;

    // Operation codes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_TMERGE = 2'd1,
        OP_SMERGE = 2'd2,
        OP_LABEL  = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K     = 1'd0,
        CFG_LIMIT = 1'd1
    } t_cfg_idx;

endpackage

// File: rtl/gsuf_ram.sv
// ----------------------------------------------------------------------------
// gsuf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gsuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/gsuf_div.sv
// ----------------------------------------------------------------------------
// gsuf_div
// Restoring divider, one quotient bit per cycle. Shared by the vertex
// modulo reduction and the k / size threshold term.
// ----------------------------------------------------------------------------
module gsuf_div #(
    parameter int NW = 24,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DW-1:0]   r_rem, n_rem;
    logic [NW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_dvs, n_dvs;

    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        ge;

    // one trial subtraction per cycle
    assign shifted = {r_rem, r_quo[NW-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = shifted >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DW-1:0] : shifted[DW-1:0];
            n_quo = {r_quo[NW-2:0], ge};
            n_cnt = r_cnt + CNTW'(1);
            if (r_cnt == CNTW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: rtl/graph_segment_union_find_top.sv
// ----------------------------------------------------------------------------
// graph_segment_union_find_top
// Union-find engine for graph-based segmentation: per-vertex parent, size,
// rank and threshold in one RAM word, walked by a small sequencer that
// shares one serial divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  command   in         start & !busy          i_operation, i_vertex_a,
//                                              i_vertex_b, i_weight
//  result    out        o_done (one cycle)     o_joined, o_label,
//                                              o_comp_size, o_set_count
//  config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
//  Root walk: reads the start vertex, then follows parent links through the
//  registered RAM read to the root. Label: one walk, then the result. Merge:
//  two walks, a decision, the child relink and root update writes, the result;
//  with no join the decision goes straight to the result; a joining threshold
//  merge first has the divider form k / size. With VERTICES below 65536 and
//  not a power of two, each beat first reduces both vertices modulo VERTICES
//  on the divider. Clear and reset: a RAM sweep writes every word, busy high;
//  clear then gives its result. The result cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module graph_segment_union_find_top #(
    parameter int VERTICES = gsuf_pkg::VERTICES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [1:0]                       i_operation,
    input  logic [gsuf_pkg::VTX_W-1:0]       i_vertex_a,
    input  logic [gsuf_pkg::VTX_W-1:0]       i_vertex_b,
    input  logic [gsuf_pkg::THR_W-1:0]       i_weight,
    input  logic                             i_cfg_we,
    input  logic [gsuf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gsuf_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             busy,
    output logic                             o_done,
    output logic                             o_joined,
    output logic [gsuf_pkg::VTX_W-1:0]       o_label,
    output logic [gsuf_pkg::OSIZE_W-1:0]     o_comp_size,
    output logic [gsuf_pkg::OCOUNT_W-1:0]    o_set_count
);

    localparam int VW   = $clog2(VERTICES);
    localparam int SW   = $clog2(VERTICES + 1);
    localparam int RW   = $clog2(VW + 1);
    localparam int TW   = gsuf_pkg::THR_W;
    localparam int XW   = gsuf_pkg::VTX_W;
    localparam int LW   = gsuf_pkg::LIMIT_W;
    localparam int WW   = VW + SW + RW + TW;
    localparam int OFS_S = VW;
    localparam int OFS_R = VW + SW;
    localparam int OFS_T = VW + SW + RW;
    // a power-of-two vertex count reduces by truncation
    localparam bit NEED_MOD = (VERTICES < 65536) && ((VERTICES & (VERTICES - 1)) != 0);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CLR   = 11'b000_0000_0010,
        S_MODA  = 11'b000_0000_0100,
        S_MODB  = 11'b000_0000_1000,
        S_WALKA = 11'b000_0001_0000,
        S_WALKB = 11'b000_0010_0000,
        S_DEC   = 11'b000_0100_0000,
        S_DIV   = 11'b000_1000_0000,
        S_WRC   = 11'b001_0000_0000,
        S_WRR   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [TW-1:0] r_k;
    logic [LW-1:0] r_limit;

    // command beat
    gsuf_pkg::t_op r_op, n_op;
    logic [XW-1:0] r_va_raw, n_va_raw;
    logic [XW-1:0] r_vb_raw, n_vb_raw;
    logic [TW-1:0] r_w, n_w;
    logic [VW-1:0] r_va, n_va;
    logic [VW-1:0] r_vb, n_vb;

    // walk and merge state
    logic          r_pend, n_pend;
    logic [VW-1:0] r_cur, n_cur;
    logic [VW-1:0] r_ra, n_ra;
    logic [VW-1:0] r_rb, n_rb;
    logic [WW-1:0] r_wa, n_wa;
    logic [WW-1:0] r_wb, n_wb;
    logic [VW-1:0] r_root, n_root;
    logic [VW-1:0] r_child, n_child;
    logic [WW-1:0] r_cword, n_cword;
    logic [SW-1:0] r_nsize, n_nsize;
    logic [RW-1:0] r_nrank, n_nrank;
    logic [TW-1:0] r_nthr, n_nthr;

    // clear sweep
    logic [VW-1:0] r_clr, n_clr;
    logic [TW-1:0] r_clr_thr, n_clr_thr;
    logic          r_quiet, n_quiet;

    // results
    logic [SW-1:0] r_count, n_count;
    logic          r_joined, n_joined;
    logic [VW-1:0] r_lab, n_lab;
    logic [SW-1:0] r_osize, n_osize;

    // divider hookup
    logic          r_dstart, n_dstart;
    logic [TW-1:0] div_dividend;
    logic [SW-1:0] div_divisor;
    logic          div_done;
    logic [TW-1:0] div_quo;
    logic [SW-1:0] div_rem;

    // RAM hookup
    logic          ram_we;
    logic [VW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [VW-1:0] ram_raddr;
    logic [WW-1:0] ram_q;
    logic [VW-1:0] q_parent;

    // decision terms
    logic [SW-1:0] sa, sb;
    logic [RW-1:0] ka, kb;
    logic [TW-1:0] ta, tb;
    logic          join_ok;
    logic          a_root;
    logic [TW:0]   thr_sum;

    // ---------------------------------------------------------------- storage
    gsuf_ram #(
        .WIDTH (WW),
        .DEPTH (VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    gsuf_div #(
        .NW (TW),
        .DW (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // divider operands: vertex reduction or k / size
    always_comb begin
        div_dividend = r_k;
        div_divisor  = r_nsize;
        case (r_state)
            S_MODA: begin
                div_dividend = {{(TW - XW){1'b0}}, r_va_raw};
                div_divisor  = SW'(VERTICES);
            end
            S_MODB: begin
                div_dividend = {{(TW - XW){1'b0}}, r_vb_raw};
                div_divisor  = SW'(VERTICES);
            end
            default: begin
                div_dividend = r_k;
                div_divisor  = r_nsize;
            end
        endcase
    end

    // walk feeds the link just read straight back as the next read address
    assign q_parent  = ram_q[VW-1:0];
    assign ram_raddr = r_pend ? q_parent : r_cur;

    // RAM writes: sweep, child relink, root update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = {r_clr_thr, {RW{1'b0}}, SW'(1), r_clr};
        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
            end
            S_WRC: begin
                ram_we    = 1'b1;
                ram_waddr = r_child;
                ram_wdata = {r_cword[WW-1:VW], r_root};
            end
            S_WRR: begin
                ram_we    = 1'b1;
                ram_waddr = r_root;
                ram_wdata = {r_nthr, r_nrank, r_nsize, r_root};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // decision on the two roots
    assign sa = r_wa[OFS_S +: SW];
    assign sb = r_wb[OFS_S +: SW];
    assign ka = r_wa[OFS_R +: RW];
    assign kb = r_wb[OFS_R +: RW];
    assign ta = r_wa[OFS_T +: TW];
    assign tb = r_wb[OFS_T +: TW];
    assign a_root = ka > kb;

    always_comb begin
        if (r_op == gsuf_pkg::OP_TMERGE) begin
            join_ok = (r_w <= ta) && (r_w <= tb);
        end else begin
            join_ok = ({{LW{1'b0}}, sa} < {{SW{1'b0}}, r_limit})
                   || ({{LW{1'b0}}, sb} < {{SW{1'b0}}, r_limit});
        end
    end

    assign thr_sum = {1'b0, r_w} + {1'b0, div_quo};

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_va_raw  = r_va_raw;
        n_vb_raw  = r_vb_raw;
        n_w       = r_w;
        n_va      = r_va;
        n_vb      = r_vb;
        n_pend    = r_pend;
        n_cur     = r_cur;
        n_ra      = r_ra;
        n_rb      = r_rb;
        n_wa      = r_wa;
        n_wb      = r_wb;
        n_root    = r_root;
        n_child   = r_child;
        n_cword   = r_cword;
        n_nsize   = r_nsize;
        n_nrank   = r_nrank;
        n_nthr    = r_nthr;
        n_clr     = r_clr;
        n_clr_thr = r_clr_thr;
        n_quiet   = r_quiet;
        n_count   = r_count;
        n_joined  = r_joined;
        n_lab     = r_lab;
        n_osize   = r_osize;
        n_dstart  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = gsuf_pkg::t_op'(i_operation);
                    n_va_raw = i_vertex_a;
                    n_vb_raw = i_vertex_b;
                    n_w      = i_weight;
                    n_joined = 1'b0;
                    n_pend   = 1'b0;
                    if (NEED_MOD) begin
                        n_state  = S_MODA;
                        n_dstart = 1'b1;
                    end else begin
                        n_state = S_CLR;
                        n_va    = VW'(i_vertex_a);
                        n_vb    = VW'(i_vertex_b);
                        n_cur   = VW'(i_vertex_a);
                        if (gsuf_pkg::t_op'(i_operation) != gsuf_pkg::OP_CLEAR) begin
                            n_state = S_WALKA;
                        end
                    end
                    n_clr     = '0;
                    n_clr_thr = r_k;
                    n_quiet   = 1'b0;
                end
            end
            S_MODA: begin
                if (div_done) begin
                    n_va     = div_rem[VW-1:0];
                    n_state  = S_MODB;
                    n_dstart = 1'b1;
                end
            end
            S_MODB: begin
                if (div_done) begin
                    n_vb  = div_rem[VW-1:0];
                    n_cur = r_va;
                    n_state = (r_op == gsuf_pkg::OP_CLEAR) ? S_CLR : S_WALKA;
                end
            end
            S_CLR: begin
                n_clr = r_clr + VW'(1);
                if (r_clr == VW'(VERTICES - 1)) begin
                    n_count  = SW'(VERTICES);
                    n_joined = 1'b0;
                    n_lab    = r_va;
                    n_osize  = SW'(1);
                    n_state  = r_quiet ? S_IDLE : S_OUT;
                end
            end
            S_WALKA: begin
                if (!r_pend) begin
                    n_pend = 1'b1;
                end else if (q_parent == r_cur) begin
                    n_ra   = r_cur;
                    n_wa   = ram_q;
                    n_cur  = r_vb;
                    n_pend = 1'b0;
                    if (r_op == gsuf_pkg::OP_LABEL) begin
                        n_lab   = r_cur;
                        n_osize = ram_q[OFS_S +: SW];
                        n_state = S_OUT;
                    end else begin
                        n_state = S_WALKB;
                    end
                end else begin
                    n_cur = q_parent;
                end
            end
            S_WALKB: begin
                if (!r_pend) begin
                    n_pend = 1'b1;
                end else if (q_parent == r_cur) begin
                    n_rb    = r_cur;
                    n_wb    = ram_q;
                    n_pend  = 1'b0;
                    n_state = S_DEC;
                end else begin
                    n_cur = q_parent;
                end
            end
            S_DEC: begin
                if ((r_ra != r_rb) && join_ok) begin
                    n_joined = 1'b1;
                    n_count  = r_count - SW'(1);
                    n_nsize  = sa + sb;
                    n_osize  = sa + sb;
                    if (a_root) begin
                        n_root  = r_ra;
                        n_child = r_rb;
                        n_cword = r_wb;
                        n_nrank = ka;
                        n_nthr  = ta;
                        n_lab   = r_ra;
                    end else begin
                        n_root  = r_rb;
                        n_child = r_ra;
                        n_cword = r_wa;
                        n_nrank = (ka == kb) ? kb + RW'(1) : kb;
                        n_nthr  = tb;
                        n_lab   = r_rb;
                    end
                    if (r_op == gsuf_pkg::OP_TMERGE) begin
                        n_state  = S_DIV;
                        n_dstart = 1'b1;
                    end else begin
                        n_state = S_WRC;
                    end
                end else begin
                    n_lab   = r_ra;
                    n_osize = sa;
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_nthr  = thr_sum[TW] ? {TW{1'b1}} : thr_sum[TW-1:0];
                    n_state = S_WRC;
                end
            end
            S_WRC: begin
                n_state = S_WRR;
            end
            S_WRR: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clr_thr <= gsuf_pkg::K_RESET;
            r_quiet   <= 1'b1;
            r_count   <= SW'(VERTICES);
            r_pend    <= 1'b0;
            r_dstart  <= 1'b0;
            r_k       <= gsuf_pkg::K_RESET;
            r_limit   <= gsuf_pkg::LIMIT_RESET;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_thr <= n_clr_thr;
            r_quiet   <= n_quiet;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_dstart  <= n_dstart;
            // configuration writes
            if (i_cfg_we) begin
                case (gsuf_pkg::t_cfg_idx'(i_cfg_idx))
                    gsuf_pkg::CFG_K:     r_k     <= i_cfg_data;
                    gsuf_pkg::CFG_LIMIT: r_limit <= i_cfg_data[LW-1:0];
                    default:             r_k     <= r_k;
                endcase
            end
        end
        r_op     <= n_op;
        r_va_raw <= n_va_raw;
        r_vb_raw <= n_vb_raw;
        r_w      <= n_w;
        r_va     <= n_va;
        r_vb     <= n_vb;
        r_cur    <= n_cur;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_wa     <= n_wa;
        r_wb     <= n_wb;
        r_root   <= n_root;
        r_child  <= n_child;
        r_cword  <= n_cword;
        r_nsize  <= n_nsize;
        r_nrank  <= n_nrank;
        r_nthr   <= n_nthr;
        r_joined <= n_joined;
        r_lab    <= n_lab;
        r_osize  <= n_osize;
    end

    // ---------------------------------------------------------------- outputs
    assign busy        = (r_state != S_IDLE);
    assign o_done      = (r_state == S_OUT);
    assign o_joined    = r_joined;
    assign o_label     = XW'(r_lab);
    assign o_comp_size = gsuf_pkg::OSIZE_W'(r_osize);
    assign o_set_count = gsuf_pkg::OCOUNT_W'(r_count);

endmodule

// File: rtl/gsuf_chk.sv
// ----------------------------------------------------------------------------
// gsuf_chk
// Port-level checks of the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
module gsuf_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // reset launches the clearing sweep
    a_rst_sweep: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // results come only while a beat is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

endmodule

bind graph_segment_union_find_top gsuf_chk u_gsuf_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segmentation union-find engine: a short
// directed table (extremes, every operation, clear, saturation, same-set and
// size-limit cases) followed by random edge streams in several register
// settings, checked against hand-typed results or a behavioral union-find.
// ----------------------------------------------------------------------------
module tb;

    localparam int  VTX_W     = gsuf_pkg::VTX_W;
    localparam int  THR_W     = gsuf_pkg::THR_W;
    localparam int  LIMIT_W   = gsuf_pkg::LIMIT_W;
    localparam int  OSIZE_W   = gsuf_pkg::OSIZE_W;
    localparam int  OCOUNT_W  = gsuf_pkg::OCOUNT_W;
    localparam int  CFG_W     = gsuf_pkg::CFG_W;
    localparam int  CFG_IDX_W = gsuf_pkg::CFG_IDX_W;
    localparam int  NV        = 65536;
    localparam int  PHASE_N   = 400;
    localparam longint LIMIT  = 4000000;

    typedef struct packed {
        logic                joined;
        logic [VTX_W-1:0]    label;
        logic [OSIZE_W-1:0]  comp_size;
        logic [OCOUNT_W-1:0] set_count;
    } t_res;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        gsuf_pkg::t_op      op;
        logic [VTX_W-1:0]   va;
        logic [VTX_W-1:0]   vb;
        logic [THR_W-1:0]   w;
        gsuf_pkg::t_cfg_idx idx;
        logic [CFG_W-1:0]   data;
        bit                 typed;
        t_res               res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [1:0]           i_operation = gsuf_pkg::OP_LABEL;
    logic [VTX_W-1:0]     i_vertex_a = '0;
    logic [VTX_W-1:0]     i_vertex_b = '0;
    logic [THR_W-1:0]     i_weight = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = gsuf_pkg::CFG_K;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 busy;
    logic                 o_done;
    logic                 o_joined;
    logic [VTX_W-1:0]     o_label;
    logic [OSIZE_W-1:0]   o_comp_size;
    logic [OCOUNT_W-1:0]  o_set_count;

    graph_segment_union_find_top dut (.*);

    always #10 i_clk = ~i_clk;

    // Shadow forest
    logic [VTX_W-1:0]   par_mem [NV];
    logic [OSIZE_W-1:0] size_mem [NV];
    logic [THR_W-1:0]   thr_mem [NV];
    byte unsigned       rank_mem [NV];
    int unsigned        sets_left;
    logic [THR_W-1:0]   k_cur;
    logic [LIMIT_W-1:0] lim_cur;

    t_res   pending_q [$];
    t_row   rows [$];
    int     errors = 0;
    int     n_items = 0;
    int     n_results = 0;
    int     n_joins = 0;
    int     n_clears = 0;
    int     burst_left = 0;
    longint cycles = 0;

    function automatic void forest_clear(logic [THR_W-1:0] thr);
        for (int v = 0; v < NV; v++) begin
            par_mem[v] = v[VTX_W-1:0];
            size_mem[v] = OSIZE_W'(1);
            thr_mem[v] = thr;
            rank_mem[v] = 8'd0;
        end
        sets_left = NV;
    endfunction

    function automatic int unsigned find_root(int unsigned v);
        int steps;
        steps = 0;
        while (par_mem[v] != v && steps < NV) begin
            v = par_mem[v];
            steps++;
        end
        return v;
    endfunction

    function automatic int unsigned link_roots(int unsigned x, int unsigned y);
        int unsigned r;
        if (rank_mem[x] > rank_mem[y]) begin
            par_mem[y] = x[VTX_W-1:0];
            size_mem[x] = size_mem[x] + size_mem[y];
            r = x;
        end else begin
            par_mem[x] = y[VTX_W-1:0];
            size_mem[y] = size_mem[y] + size_mem[x];
            if (rank_mem[x] == rank_mem[y] && rank_mem[y] < 255) rank_mem[y]++;
            r = y;
        end
        if (sets_left > 0) sets_left--;
        return r;
    endfunction

    // Apply one command to the shadow forest and return its expected beat
    function automatic t_res segment_step(gsuf_pkg::t_op op, int unsigned va,
                                          int unsigned vb, logic [THR_W-1:0] w);
        t_res        res;
        int unsigned ra, rb, r;
        longint      t;
        res.joined = 1'b0;
        if (op == gsuf_pkg::OP_CLEAR) begin
            forest_clear(k_cur);
        end else if (op == gsuf_pkg::OP_TMERGE || op == gsuf_pkg::OP_SMERGE) begin
            ra = find_root(va);
            rb = find_root(vb);
            if (ra != rb) begin
                if (op == gsuf_pkg::OP_TMERGE) begin
                    if (w <= thr_mem[ra] && w <= thr_mem[rb]) begin
                        r = link_roots(ra, rb);
                        t = longint'(w) + longint'(k_cur / size_mem[r]);
                        thr_mem[r] = (t > 24'hFFFFFF) ? 24'hFFFFFF : t[THR_W-1:0];
                        res.joined = 1'b1;
                    end
                end else if (size_mem[ra] < lim_cur || size_mem[rb] < lim_cur) begin
                    r = link_roots(ra, rb);
                    res.joined = 1'b1;
                end
            end
        end
        r = find_root(va);
        res.label = r[VTX_W-1:0];
        res.comp_size = size_mem[r];
        res.set_count = sets_left[OCOUNT_W-1:0];
        return res;
    endfunction

    // Drive one command and hold it until accepted
    task automatic send_cmd(gsuf_pkg::t_op op, logic [VTX_W-1:0] va,
                            logic [VTX_W-1:0] vb, logic [THR_W-1:0] w,
                            bit typed, t_res typed_res);
        t_res pred;
        int   gap;
        start <= 1'b1;
        i_operation <= op;
        i_vertex_a <= va;
        i_vertex_b <= vb;
        i_weight <= w;
        do @(posedge i_clk); while (busy);
        pred = segment_step(op, va, vb, w);
        pending_q.push_back(typed ? typed_res : pred);
        n_items++;
        if (op == gsuf_pkg::OP_CLEAR) n_clears++;
        // burst and gap pattern of the sender
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(0, 5);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
        end
    endtask

    // Pause until every expected beat is in and the block is idle
    task automatic drain;
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(gsuf_pkg::t_cfg_idx idx, logic [CFG_W-1:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == gsuf_pkg::CFG_K) k_cur = data[THR_W-1:0];
        else lim_cur = data[LIMIT_W-1:0];
    endtask

    function automatic t_res mk_res(bit j, int unsigned l, int unsigned s, int unsigned c);
        t_res r;
        r.joined = j;
        r.label = l[VTX_W-1:0];
        r.comp_size = s[OSIZE_W-1:0];
        r.set_count = c[OCOUNT_W-1:0];
        return r;
    endfunction

    function automatic void add_item(gsuf_pkg::t_op op, int unsigned va, int unsigned vb,
                                     int unsigned w, bit typed, t_res res);
        t_row row;
        row.kind = ROW_ITEM;
        row.op = op;
        row.va = va[VTX_W-1:0];
        row.vb = vb[VTX_W-1:0];
        row.w = w[THR_W-1:0];
        row.idx = gsuf_pkg::CFG_K;
        row.data = '0;
        row.typed = typed;
        row.res = res;
        rows.push_back(row);
    endfunction

    function automatic void add_cfg(gsuf_pkg::t_cfg_idx idx, int unsigned data);
        t_row row;
        row.kind = ROW_CFG;
        row.op = gsuf_pkg::OP_LABEL;
        row.va = '0;
        row.vb = '0;
        row.w = '0;
        row.idx = idx;
        row.data = data[CFG_W-1:0];
        row.typed = 1'b0;
        row.res = '0;
        rows.push_back(row);
    endfunction

    // Vertices cluster in a window so components actually grow
    function automatic logic [VTX_W-1:0] pick_vtx(logic [9:0] win);
        logic [VTX_W-1:0] v;
        v = VTX_W'($urandom());
        if ($urandom_range(0, 9) < 8) v = {win, v[5:0]};
        return v;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_done) begin
            got = {o_joined, o_label, o_comp_size, o_set_count};
            n_results++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: result beat with none expected");
            end else begin
                want = pending_q.pop_front();
                if (got.joined) n_joins++;
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: joined %0d/%0d label %0d/%0d size %0d/%0d count %0d/%0d (exp/got)",
                                 want.joined, got.joined, want.label, got.label,
                                 want.comp_size, got.comp_size, want.set_count,
                                 got.set_count);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        gsuf_pkg::t_op    op;
        logic [9:0]       win;
        logic [THR_W-1:0] w_run, w;
        int               sel;

        k_cur = gsuf_pkg::K_RESET;
        lim_cur = gsuf_pkg::LIMIT_RESET;
        forest_clear(gsuf_pkg::K_RESET);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        add_item(gsuf_pkg::OP_LABEL, 0, 0, 0, 1, mk_res(0, 0, 1, 65536));
        add_item(gsuf_pkg::OP_LABEL, 65535, 65535, 24'hFFFFFF, 1,
                 mk_res(0, 65535, 1, 65536));
        add_item(gsuf_pkg::OP_TMERGE, 0, 1, 0, 1, mk_res(1, 1, 2, 65535));
        add_item(gsuf_pkg::OP_TMERGE, 0, 1, 0, 1, mk_res(0, 1, 2, 65535));
        add_item(gsuf_pkg::OP_TMERGE, 2, 3, 24'hFFFFFF, 1, mk_res(0, 2, 1, 65535));
        add_item(gsuf_pkg::OP_SMERGE, 4, 5, 0, 1, mk_res(0, 4, 1, 65535));
        add_item(gsuf_pkg::OP_TMERGE, 65535, 65534, 128000, 1,
                 mk_res(1, 65534, 2, 65534));
        add_item(gsuf_pkg::OP_TMERGE, 0, 2, 1000, 0, '0);
        add_item(gsuf_pkg::OP_TMERGE, 3, 0, 1500, 0, '0);
        add_item(gsuf_pkg::OP_LABEL, 3, 0, 0, 0, '0);
        add_cfg(gsuf_pkg::CFG_LIMIT, 3);
        add_item(gsuf_pkg::OP_SMERGE, 4, 5, 0, 0, '0);
        add_item(gsuf_pkg::OP_SMERGE, 6, 4, 0, 0, '0);
        add_item(gsuf_pkg::OP_SMERGE, 0, 4, 0, 0, '0);
        add_cfg(gsuf_pkg::CFG_K, 24'hFFFFFF);
        add_item(gsuf_pkg::OP_TMERGE, 8, 9, 24'hFFFFFF, 1, mk_res(0, 8, 1, 65530));
        add_item(gsuf_pkg::OP_CLEAR, 16'hAAAA, 0, 0, 1, mk_res(0, 16'hAAAA, 1, 65536));
        add_item(gsuf_pkg::OP_TMERGE, 16'hAAAA, 16'h5555, 24'hFFFFFF, 1,
                 mk_res(1, 16'h5555, 2, 65535));
        add_item(gsuf_pkg::OP_TMERGE, 16'h5555, 16'hFFFF, 24'hFFFFFF, 0, '0);
        add_cfg(gsuf_pkg::CFG_K, 0);
        add_item(gsuf_pkg::OP_CLEAR, 0, 0, 0, 0, '0);
        add_item(gsuf_pkg::OP_TMERGE, 10, 11, 0, 0, '0);
        add_item(gsuf_pkg::OP_TMERGE, 12, 13, 1, 0, '0);
        add_cfg(gsuf_pkg::CFG_LIMIT, 65536);
        add_item(gsuf_pkg::OP_SMERGE, 100, 200, 0, 0, '0);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
            else send_cmd(rows[i].op, rows[i].va, rows[i].vb, rows[i].w,
                          rows[i].typed, rows[i].res);
        end

        // Random phases, each in its own register setting
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(gsuf_pkg::CFG_K, gsuf_pkg::K_RESET);
                    write_reg(gsuf_pkg::CFG_LIMIT, CFG_W'(0));
                end
                1: begin
                    write_reg(gsuf_pkg::CFG_K, 24'hFFFFFF);
                    write_reg(gsuf_pkg::CFG_LIMIT, CFG_W'(65536));
                end
                2: begin
                    write_reg(gsuf_pkg::CFG_K, CFG_W'(0));
                    write_reg(gsuf_pkg::CFG_LIMIT, CFG_W'(1));
                end
                default: begin
                    write_reg(gsuf_pkg::CFG_K, CFG_W'($urandom_range(0, 24'hFFFFFF)));
                    write_reg(gsuf_pkg::CFG_LIMIT, CFG_W'($urandom_range(2, 16)));
                end
            endcase
            win = 10'($urandom());
            w_run = '0;
            send_cmd(gsuf_pkg::OP_CLEAR, pick_vtx(win), VTX_W'($urandom()),
                     THR_W'($urandom()), 0, '0);
            for (int n = 0; n < PHASE_N; n++) begin
                sel = $urandom_range(0, 99);
                op = (sel < 45) ? gsuf_pkg::OP_TMERGE
                   : (sel < 70) ? gsuf_pkg::OP_SMERGE : gsuf_pkg::OP_LABEL;
                // mostly ascending weights, some out-of-order noise
                if ($urandom_range(0, 99) < 85) begin
                    w_run = (w_run > 24'hFFF000) ? w_run
                                                 : w_run + THR_W'($urandom_range(0, 300));
                    w = w_run;
                end else begin
                    w = THR_W'($urandom());
                end
                send_cmd(op, pick_vtx(win), pick_vtx(win), w, 0, '0);
            end
        end

        // Wind down
        drain();
        repeat (200) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            errors++;
            $display("ERROR: %0d expected beats never arrived", pending_q.size());
        end
        $display("Ran %0d commands (%0d clears), %0d result beats, %0d joins,",
                 n_items, n_clears, n_results, n_joins);
        $display("over four register settings plus a directed table; %0d mismatches.",
                 errors);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: filelist.f
rtl/gsuf_pkg.sv
rtl/gsuf_ram.sv
rtl/gsuf_div.sv
rtl/graph_segment_union_find_top.sv
rtl/gsuf_chk.sv
tb/tb.sv
